>>> sv/alu_16bit_with_compare_flags_defines.svh
// Assertion macros for the ALU block.
// Used by the top level; no dependencies.
`ifndef ALU_16BIT_WITH_COMPARE_FLAGS_DEFINES_SVH
`define ALU_16BIT_WITH_COMPARE_FLAGS_DEFINES_SVH
`ifndef SYNTHESIS
`define ALU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ALU_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALU_ASSERT(label, clk, rst_n, prop, msg)
`define ALU_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

>>> sv/alu16_pkg.sv
// Package for the ALU block: operation codes, compare flag positions.
// No dependencies.
package alu16_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_MOD = 4'd4, OP_AND = 4'd5, OP_NOR = 4'd6, OP_XOR = 4'd7,
        OP_CMP = 4'd8, OP_ARS = 4'd9, OP_LRS = 4'd10, OP_LLS = 4'd11
    } op_t;
    localparam int CMP_W = 11;
    localparam int CF_ZERO = 0;
    localparam int CF_EQ = 1;
    localparam int CF_NE = 2;
    localparam int CF_ULT = 3;
    localparam int CF_ULE = 4;
    localparam int CF_UGT = 5;
    localparam int CF_UGE = 6;
    localparam int CF_SLT = 7;
    localparam int CF_SLE = 8;
    localparam int CF_SGT = 9;
    localparam int CF_SGE = 10;
endpackage

>>> sv/alu_16bit_with_compare_flags.sv
// Top level of the pipelined ALU with compare flags.
// Depends on alu16_pkg, alu16_div and the assertion macro header.
// One operation enters per cycle unless the output stalls. The divider resolves
// one quotient bit per stage. Every operation travels the same pipeline so
// results leave in order. A stall at the output holds the whole pipeline;
// ready follows the output register being free or taken.
`include "alu_16bit_with_compare_flags_defines.svh"
module alu_16bit_with_compare_flags #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [3:0]            action,
    input  logic [DATA_WIDTH-1:0] operand_a,
    input  logic [DATA_WIDTH-1:0] operand_b,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] result_word,
    output logic                  carry_flag,
    output logic                  overflow_flag,
    output logic [alu16_pkg::CMP_W-1:0] compare_flags
);
    localparam int W = DATA_WIDTH;
    localparam int SW = $clog2(W);
    localparam int TAG_W = 4 + W + 1 + 1 + alu16_pkg::CMP_W + 1;

    logic advance;
    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    // stage 1: register operands
    logic         s1_v_reg;
    logic [3:0]   s1_op_reg;
    logic [W-1:0] s1_a_reg, s1_b_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (advance)
            s1_v_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg <= action;
            s1_a_reg  <= operand_a;
            s1_b_reg  <= operand_b;
        end
    end

    // stage 2: add, subtract, logic, compare and shift results, divide flags and the raw product
    logic [W-1:0]   res_next;
    logic           car_next, ovf_next;
    logic [alu16_pkg::CMP_W-1:0] cmp_next;
    logic [W:0]     sum, dif;
    logic           eq, ult, slt, longsh, dv_zero, dv_min;
    logic [SW-1:0]  sh;
    logic [2*W-1:0] lls_wide;
    always_comb
    begin
        sum = {1'b0, s1_a_reg} + {1'b0, s1_b_reg};
        dif = {1'b0, s1_a_reg} - {1'b0, s1_b_reg};
        eq  = s1_a_reg == s1_b_reg;
        ult = dif[W];
        slt = ({~s1_a_reg[W-1], s1_a_reg[W-2:0]} < {~s1_b_reg[W-1], s1_b_reg[W-2:0]});
        longsh = s1_b_reg >= W'(W) || (W < 64 && (s1_b_reg >> SW) != '0);
        sh = s1_b_reg[SW-1:0];
        lls_wide = {{W{1'b0}}, s1_a_reg} << sh;
        dv_zero = s1_b_reg == '0;
        dv_min = s1_a_reg == {1'b1, {(W-1){1'b0}}} && s1_b_reg == {W{1'b1}};
        res_next = '0;
        car_next = 1'b0;
        ovf_next = 1'b0;
        cmp_next = '0;
        case (s1_op_reg)
            alu16_pkg::OP_ADD:
            begin
                res_next = sum[W-1:0];
                car_next = sum[W];
                ovf_next = (s1_a_reg[W-1] == s1_b_reg[W-1]) && (sum[W-1] != s1_a_reg[W-1]);
            end
            alu16_pkg::OP_SUB:
            begin
                res_next = dif[W-1:0];
                car_next = ult;
                ovf_next = (s1_a_reg[W-1] != s1_b_reg[W-1]) && (dif[W-1] != s1_a_reg[W-1]);
            end
            alu16_pkg::OP_DIV, alu16_pkg::OP_MOD:
            begin
                ovf_next = dv_zero;
                car_next = !dv_zero && dv_min;
            end
            alu16_pkg::OP_AND: res_next = s1_a_reg & s1_b_reg;
            alu16_pkg::OP_NOR: res_next = ~(s1_a_reg | s1_b_reg);
            alu16_pkg::OP_XOR: res_next = s1_a_reg ^ s1_b_reg;
            alu16_pkg::OP_CMP:
            begin
                cmp_next[alu16_pkg::CF_ZERO] = s1_a_reg == '0;
                cmp_next[alu16_pkg::CF_EQ]   = eq;
                cmp_next[alu16_pkg::CF_NE]   = !eq;
                cmp_next[alu16_pkg::CF_ULT]  = ult;
                cmp_next[alu16_pkg::CF_ULE]  = ult || eq;
                cmp_next[alu16_pkg::CF_UGT]  = !ult && !eq;
                cmp_next[alu16_pkg::CF_UGE]  = !ult;
                cmp_next[alu16_pkg::CF_SLT]  = slt;
                cmp_next[alu16_pkg::CF_SLE]  = slt || eq;
                cmp_next[alu16_pkg::CF_SGT]  = !slt && !eq;
                cmp_next[alu16_pkg::CF_SGE]  = !slt;
            end
            alu16_pkg::OP_ARS:
                res_next = longsh ? {W{s1_a_reg[W-1]}} : W'($signed(s1_a_reg) >>> sh);
            alu16_pkg::OP_LRS:
                res_next = longsh ? '0 : (s1_a_reg >> sh);
            alu16_pkg::OP_LLS:
            begin
                res_next = longsh ? '0 : lls_wide[W-1:0];
                ovf_next = longsh ? (s1_a_reg != '0) : (lls_wide[2*W-1:W] != '0);
            end
            default: ;
        endcase
    end

    logic         s2_v_reg;
    logic [3:0]   s2_op_reg;
    logic [W-1:0] s2_a_reg, s2_b_reg, s2_res_reg;
    logic         s2_car_reg, s2_ovf_reg, s2_dz_reg;
    logic [alu16_pkg::CMP_W-1:0] s2_cmp_reg;
    logic [2*W-1:0] s2_prod_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_v_reg <= 1'b0;
        else if (advance)
            s2_v_reg <= s1_v_reg;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_a_reg    <= s1_a_reg;
            s2_b_reg    <= s1_b_reg;
            s2_res_reg  <= res_next;
            s2_car_reg  <= car_next;
            s2_ovf_reg  <= ovf_next;
            s2_cmp_reg  <= cmp_next;
            s2_dz_reg   <= dv_zero || dv_min;
            s2_prod_reg <= (2*W)'(s1_a_reg) * (2*W)'(s1_b_reg);
        end
    end

    // stage 3: product result and flags
    logic [W-1:0] m_res;
    logic         m_car, m_ovf;
    always_comb
    begin
        m_res = s2_res_reg;
        m_car = s2_car_reg;
        m_ovf = s2_ovf_reg;
        if (s2_op_reg == alu16_pkg::OP_MUL)
        begin
            m_res = s2_prod_reg[W-1:0];
            m_car = s2_prod_reg[2*W-1:W] != '0;
            m_ovf = s2_prod_reg[2*W-1:W] != {W{s2_prod_reg[W-1]}};
        end
    end

    // divider stages carry the other results alongside
    logic [TAG_W-1:0] tag_in, tag_out;
    logic             dv_valid;
    logic [W-1:0]     quo, rem;
    assign tag_in = {s2_op_reg, m_res, m_car, m_ovf, s2_cmp_reg, s2_dz_reg};

    alu16_div #(.W(W), .TAG_W(TAG_W)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s2_v_reg),
        .dividend  (s2_a_reg),
        .divisor   (s2_b_reg),
        .tag_in    (tag_in),
        .out_valid (dv_valid),
        .quotient  (quo),
        .remainder (rem),
        .tag_out   (tag_out)
    );

    logic [3:0]   t_op;
    logic [W-1:0] t_res;
    logic         t_car, t_ovf, t_sp;
    logic [alu16_pkg::CMP_W-1:0] t_cmp;
    logic [W-1:0] f_res;
    assign {t_op, t_res, t_car, t_ovf, t_cmp, t_sp} = tag_out;
    always_comb
    begin
        f_res = t_res;
        if (!t_sp && t_op == alu16_pkg::OP_DIV)
            f_res = quo;
        else if (!t_sp && t_op == alu16_pkg::OP_MOD)
            f_res = rem;
    end

    logic out_v_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (advance)
            out_v_reg <= dv_valid;
    end
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_word   <= f_res;
            carry_flag    <= t_car;
            overflow_flag <= t_ovf;
            compare_flags <= t_cmp;
        end
    end
    assign out_valid = out_v_reg;

    `ALU_ASSERT(a_stall_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(result_word), "output changed during stall")
    `ALU_ASSERT(a_ready, clk, rst_n, in_ready == (!out_valid || out_ready), "ready mismatch")
    `ALU_ASSERT(a_cmp_only, clk, rst_n, out_valid && compare_flags != '0 |-> result_word == '0 && !carry_flag && !overflow_flag, "compare flags with other result")
endmodule

>>> sv/alu16_div.sv
// Pipelined restoring divider, one quotient bit per stage, stall-aware.
// Depends on nothing; carries a tag of width TAG_W along.
module alu16_div #(
    parameter int W = 16,
    parameter int TAG_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [W-1:0]     dividend,
    input  logic [W-1:0]     divisor,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [W-1:0]     quotient,
    output logic [W-1:0]     remainder,
    output logic [TAG_W-1:0] tag_out
);
    logic [W-1:0]     q_reg [1:W];
    logic [W-1:0]     r_reg [1:W];
    logic [W-1:0]     d_reg [1:W];
    logic [TAG_W-1:0] t_reg [1:W];
    logic [W:1]       v_reg;
    logic [W-1:0]     q_cur [W];
    logic [W-1:0]     r_cur [W];
    logic [W-1:0]     d_cur [W];
    logic [TAG_W-1:0] t_cur [W];
    logic [W-1:0]     v_cur;
    logic [W:0]       trial [W];
    logic [W:0]       diff [W];

    always_comb
    begin
        q_cur[0] = dividend;
        r_cur[0] = '0;
        d_cur[0] = divisor;
        t_cur[0] = tag_in;
        v_cur[0] = in_valid;
        for (int s = 1; s < W; s++)
        begin
            q_cur[s] = q_reg[s];
            r_cur[s] = r_reg[s];
            d_cur[s] = d_reg[s];
            t_cur[s] = t_reg[s];
            v_cur[s] = v_reg[s];
        end
        for (int s = 0; s < W; s++)
        begin
            trial[s] = {r_cur[s], q_cur[s][W-1]};
            diff[s]  = trial[s] - {1'b0, d_cur[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= v_cur;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < W; s++)
            begin
                if (diff[s][W])
                begin
                    r_reg[s+1] <= trial[s][W-1:0];
                    q_reg[s+1] <= {q_cur[s][W-2:0], 1'b0};
                end
                else
                begin
                    r_reg[s+1] <= diff[s][W-1:0];
                    q_reg[s+1] <= {q_cur[s][W-2:0], 1'b1};
                end
                d_reg[s+1] <= d_cur[s];
                t_reg[s+1] <= t_cur[s];
            end
        end
    end

    assign out_valid = v_reg[W];
    assign quotient  = q_reg[W];
    assign remainder = r_reg[W];
    assign tag_out   = t_reg[W];
endmodule
